>>> hw/rtl/hsnl_pkg.sv
// shared types and constants of the noise level estimator
package hsnl_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int COUNT_W        = 13;
  localparam int AVG_W          = 16;
  localparam int MAX_SAMPLES    = 4096;
  localparam int MIN_TEST_INDEX = 5;
  localparam int PSUM_W         = 36;
  localparam int SQ_W           = 2 * SAMPLE_W;
  localparam int SSUM_W         = 60;
  localparam int MUL_W          = 32;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int JN_W           = 28;
  localparam int K_W            = 40;
  localparam int P2_W           = 2 * PSUM_W;
  localparam int ACC_W          = 100;
  localparam int FRAC_BITS      = 8;
  localparam int DIV_W          = PSUM_W + FRAC_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_W);
  localparam int MEAN_W         = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int S_TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_PAY_W      = MEAN_W + COUNT_W;
  localparam int M_TDATA_W      = ((OUT_PAY_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVERAGES     = 1'b0,
    REG_SAMPLE_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_JN,
    ST_K,
    ST_PLL,
    ST_PLH,
    ST_PHH,
    ST_Q0,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_L0,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_L4,
    ST_CMP,
    ST_END,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/hildebrand_sekhon_noise_level.sv
// Hildebrand-Sekhon noise level estimator: one sequencer around one 32x32 multiplier.
// Feed the sorted power samples of one spectrum on s_axis, one per request. A sample
// is taken only once the one before is done. Each is squared, and once the index passes
// max(5, 0.75 times the count), the square and the white-noise test comparison run as
// 13 products on the single shared multiplier. After the stop, samples skip both the
// square and the test. After the last sample of a spectrum, a one-bit-per-cycle divider
// forms the mean and the output register is loaded (later while an earlier result
// still waits there); the result carries the mean as 24.8 fixed point and the number
// of samples used, and the next spectrum may start while it waits on m_axis.
// Write configuration only between spectra while the block is idle.
module hildebrand_sekhon_noise_level (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hsnl_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // sample[23:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hsnl_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // noise_level[31:0], samples_used[44:32]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hsnl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsnl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COUNT_W = hsnl_pkg::COUNT_W;

  hsnl_pkg::state_t state, state_next;

  logic [hsnl_pkg::AVG_W-1:0]     averages;
  logic [COUNT_W-1:0]             sample_count;
  logic [hsnl_pkg::SAMPLE_W-1:0]  s_reg;
  logic [hsnl_pkg::SAMPLE_W-1:0]  prev;
  logic [hsnl_pkg::SQ_W-1:0]      prev_sq;
  logic [hsnl_pkg::SQ_W-1:0]      cur_sq;
  logic [hsnl_pkg::PSUM_W-1:0]    power_sum;
  logic [hsnl_pkg::SSUM_W-1:0]    square_sum;
  logic [COUNT_W-1:0]             sample_index;
  logic [COUNT_W-1:0]             used_count;
  logic                           stopped;
  logic [hsnl_pkg::PROD_W-1:0]    prod;
  logic [hsnl_pkg::ACC_W-1:0]     acc;
  logic [hsnl_pkg::ACC_W-1:0]     rhs;
  logic [hsnl_pkg::JN_W-1:0]      bb;
  logic [hsnl_pkg::K_W-1:0]       kk;
  logic [hsnl_pkg::P2_W-1:0]      p2;
  logic [hsnl_pkg::DIV_W-1:0]     div_q;
  logic [COUNT_W-1:0]             div_rem;
  logic [hsnl_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [COUNT_W-1:0]             divisor;
  logic                           out_valid;
  logic [hsnl_pkg::M_TDATA_W-1:0] out_data;

  // control decoded from the state
  logic [hsnl_pkg::MUL_W-1:0] mul_a, mul_b;
  logic                       acc_add, acc_clr;
  logic [6:0]                 acc_shift;
  logic                       out_load;

  logic [hsnl_pkg::ACC_W-1:0] acc_sum;
  logic [COUNT_W-1:0]         count_eff;
  logic [COUNT_W-1:0]         index_inc;
  logic [COUNT_W-1:0]         index_dec;
  logic [COUNT_W+1:0]         index_x4;
  logic [COUNT_W+1:0]         count_x3;
  logic                       test_en;
  logic                       last;
  logic [COUNT_W:0]           rem_sh;
  logic                       rem_ge;
  logic [COUNT_W:0]           rem_sub;

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // count zero acts as one, above the maximum it saturates
  always_comb begin
    if (sample_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (sample_count > COUNT_W'(hsnl_pkg::MAX_SAMPLES)) begin
      count_eff = COUNT_W'(hsnl_pkg::MAX_SAMPLES);
    end else begin
      count_eff = sample_count;
    end
  end

  assign index_inc = sample_index + COUNT_W'(1);
  assign index_dec = sample_index - COUNT_W'(1);
  assign index_x4  = {sample_index, 2'b00};
  assign count_x3  = {2'b00, count_eff} + {1'b0, count_eff, 1'b0};
  assign test_en   = (sample_index > COUNT_W'(hsnl_pkg::MIN_TEST_INDEX)) &&
                     (index_x4 > count_x3);
  assign last      = !(index_inc < count_eff);

  assign acc_sum = (acc_clr ? '0 : acc) + (hsnl_pkg::ACC_W'(prod) << acc_shift);

  // restoring divider step
  assign rem_sh  = {div_rem, div_q[hsnl_pkg::DIV_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsnl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hsnl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = stopped ? hsnl_pkg::ST_END : hsnl_pkg::ST_SQ;
        end
      end
      hsnl_pkg::ST_SQ:  state_next = hsnl_pkg::ST_JN;
      hsnl_pkg::ST_JN:  state_next = test_en ? hsnl_pkg::ST_K : hsnl_pkg::ST_END;
      hsnl_pkg::ST_K:   state_next = hsnl_pkg::ST_PLL;
      hsnl_pkg::ST_PLL: state_next = hsnl_pkg::ST_PLH;
      hsnl_pkg::ST_PLH: state_next = hsnl_pkg::ST_PHH;
      hsnl_pkg::ST_PHH: state_next = hsnl_pkg::ST_Q0;
      hsnl_pkg::ST_Q0:  state_next = hsnl_pkg::ST_R0;
      hsnl_pkg::ST_R0:  state_next = hsnl_pkg::ST_R1;
      hsnl_pkg::ST_R1:  state_next = hsnl_pkg::ST_R2;
      hsnl_pkg::ST_R2:  state_next = hsnl_pkg::ST_L0;
      hsnl_pkg::ST_L0:  state_next = hsnl_pkg::ST_L1;
      hsnl_pkg::ST_L1:  state_next = hsnl_pkg::ST_L2;
      hsnl_pkg::ST_L2:  state_next = hsnl_pkg::ST_L3;
      hsnl_pkg::ST_L3:  state_next = hsnl_pkg::ST_L4;
      hsnl_pkg::ST_L4:  state_next = hsnl_pkg::ST_CMP;
      hsnl_pkg::ST_CMP: state_next = hsnl_pkg::ST_END;
      hsnl_pkg::ST_END: state_next = last ? hsnl_pkg::ST_DIV : hsnl_pkg::ST_IDLE;
      hsnl_pkg::ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = hsnl_pkg::ST_OUT;
        end
      end
      hsnl_pkg::ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          state_next = hsnl_pkg::ST_IDLE;
        end
      end
      default: state_next = hsnl_pkg::ST_IDLE;
    endcase
  end

  // multiplier operands and accumulator control per step
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    acc_add       = 1'b0;
    acc_clr       = 1'b0;
    acc_shift     = 7'd0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state)
      hsnl_pkg::ST_IDLE: s_axis_tready = 1'b1;
      hsnl_pkg::ST_SQ: begin
        mul_a = hsnl_pkg::MUL_W'(s_reg);
        mul_b = hsnl_pkg::MUL_W'(s_reg);
      end
      hsnl_pkg::ST_JN: begin
        mul_a = hsnl_pkg::MUL_W'(sample_index);
        mul_b = hsnl_pkg::MUL_W'(averages);
      end
      hsnl_pkg::ST_K: begin
        // j*navg*(j-1)
        mul_a = hsnl_pkg::MUL_W'(prod[hsnl_pkg::JN_W-1:0]);
        mul_b = hsnl_pkg::MUL_W'(index_dec);
      end
      hsnl_pkg::ST_PLL: begin
        mul_a = power_sum[31:0];
        mul_b = power_sum[31:0];
      end
      hsnl_pkg::ST_PLH: begin
        mul_a     = power_sum[31:0];
        mul_b     = hsnl_pkg::MUL_W'(power_sum[hsnl_pkg::PSUM_W-1:32]);
        acc_add   = 1'b1;
        acc_clr   = 1'b1;
      end
      hsnl_pkg::ST_PHH: begin
        mul_a     = hsnl_pkg::MUL_W'(power_sum[hsnl_pkg::PSUM_W-1:32]);
        mul_b     = hsnl_pkg::MUL_W'(power_sum[hsnl_pkg::PSUM_W-1:32]);
        acc_add   = 1'b1;
        acc_shift = 7'd33;
      end
      hsnl_pkg::ST_Q0: begin
        acc_add   = 1'b1;
        acc_shift = 7'd64;
      end
      hsnl_pkg::ST_R0: begin
        mul_a = p2[31:0];
        mul_b = hsnl_pkg::MUL_W'(bb);
      end
      hsnl_pkg::ST_R1: begin
        mul_a     = p2[63:32];
        mul_b     = hsnl_pkg::MUL_W'(bb);
        acc_add   = 1'b1;
        acc_clr   = 1'b1;
      end
      hsnl_pkg::ST_R2: begin
        mul_a     = hsnl_pkg::MUL_W'(p2[hsnl_pkg::P2_W-1:64]);
        mul_b     = hsnl_pkg::MUL_W'(bb);
        acc_add   = 1'b1;
        acc_shift = 7'd32;
      end
      hsnl_pkg::ST_L0: begin
        mul_a     = square_sum[31:0];
        mul_b     = kk[31:0];
        acc_add   = 1'b1;
        acc_shift = 7'd64;
      end
      hsnl_pkg::ST_L1: begin
        mul_a     = square_sum[31:0];
        mul_b     = hsnl_pkg::MUL_W'(kk[hsnl_pkg::K_W-1:32]);
        acc_add   = 1'b1;
        acc_clr   = 1'b1;
      end
      hsnl_pkg::ST_L2: begin
        mul_a     = hsnl_pkg::MUL_W'(square_sum[hsnl_pkg::SSUM_W-1:32]);
        mul_b     = kk[31:0];
        acc_add   = 1'b1;
        acc_shift = 7'd32;
      end
      hsnl_pkg::ST_L3: begin
        mul_a     = hsnl_pkg::MUL_W'(square_sum[hsnl_pkg::SSUM_W-1:32]);
        mul_b     = hsnl_pkg::MUL_W'(kk[hsnl_pkg::K_W-1:32]);
        acc_add   = 1'b1;
        acc_shift = 7'd32;
      end
      hsnl_pkg::ST_L4: begin
        acc_add   = 1'b1;
        acc_shift = 7'd64;
      end
      hsnl_pkg::ST_CMP, hsnl_pkg::ST_END, hsnl_pkg::ST_DIV: ;
      hsnl_pkg::ST_OUT: out_load = !out_valid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (acc_add) begin
      acc <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      averages     <= hsnl_pkg::AVG_W'(1);
      sample_count <= COUNT_W'(hsnl_pkg::MAX_SAMPLES);
      power_sum    <= '0;
      square_sum   <= '0;
      sample_index <= '0;
      used_count   <= '0;
      stopped      <= 1'b0;
      out_valid    <= 1'b0;
      div_cnt      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (hsnl_pkg::cfg_reg_t'(cfg_index))
          hsnl_pkg::REG_AVERAGES:     averages     <= cfg_data;
          hsnl_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data[COUNT_W-1:0];
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        hsnl_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            s_reg <= s_axis_tdata[hsnl_pkg::SAMPLE_W-1:0];
            if (!stopped) begin
              power_sum <= power_sum +
                           hsnl_pkg::PSUM_W'(s_axis_tdata[hsnl_pkg::SAMPLE_W-1:0]);
            end
          end
        end
        hsnl_pkg::ST_JN: begin
          square_sum <= square_sum + hsnl_pkg::SSUM_W'(prod[hsnl_pkg::SQ_W-1:0]);
          cur_sq     <= prod[hsnl_pkg::SQ_W-1:0];
        end
        hsnl_pkg::ST_K: begin
          // threshold factor j*navg + j - 1
          bb <= prod[hsnl_pkg::JN_W-1:0] + hsnl_pkg::JN_W'(index_dec);
        end
        hsnl_pkg::ST_PLL: kk <= prod[hsnl_pkg::K_W-1:0];
        hsnl_pkg::ST_Q0:  p2 <= acc_sum[hsnl_pkg::P2_W-1:0];
        hsnl_pkg::ST_L0:  rhs <= acc_sum;
        hsnl_pkg::ST_CMP: begin
          // not white: take the previous sample back out and freeze
          if (acc > rhs) begin
            power_sum  <= power_sum - hsnl_pkg::PSUM_W'(prev);
            square_sum <= square_sum - hsnl_pkg::SSUM_W'(prev_sq);
            used_count <= sample_index;
            stopped    <= 1'b1;
          end
        end
        hsnl_pkg::ST_END: begin
          prev    <= s_reg;
          prev_sq <= cur_sq;
          if (last) begin
            divisor      <= stopped ? used_count : index_inc;
            div_q        <= {power_sum, hsnl_pkg::FRAC_BITS'(0)};
            div_rem      <= '0;
            div_cnt      <= hsnl_pkg::DIV_CNT_W'(hsnl_pkg::DIV_W - 1);
            power_sum    <= '0;
            square_sum   <= '0;
            sample_index <= '0;
            used_count   <= '0;
            stopped      <= 1'b0;
          end else begin
            sample_index <= index_inc;
          end
        end
        hsnl_pkg::ST_DIV: begin
          div_rem <= rem_ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
          div_q   <= {div_q[hsnl_pkg::DIV_W-2:0], rem_ge};
          div_cnt <= div_cnt - hsnl_pkg::DIV_CNT_W'(1);
        end
        hsnl_pkg::ST_OUT: begin
          if (out_load) begin
            out_data <= hsnl_pkg::M_TDATA_W'({divisor, div_q[hsnl_pkg::MEAN_W-1:0]});
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/hsnl_checker.sv
// port-level checks of the noise level estimator and their bind
module hsnl_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hsnl_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int USED_LO = hsnl_pkg::MEAN_W;
  localparam int USED_HI = hsnl_pkg::MEAN_W + hsnl_pkg::COUNT_W - 1;

  // a result waiting on the output holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the divisor of a result is never zero nor above the maximum count
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[USED_HI:USED_LO] != '0) &&
                      (m_axis_tdata[USED_HI:USED_LO] <=
                       hsnl_pkg::COUNT_W'(hsnl_pkg::MAX_SAMPLES)))
    else $error("samples_used out of range");

  // the sequencer is busy in the cycle after it takes a sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample request taken back to back");

endmodule

bind hildebrand_sekhon_noise_level hsnl_checker u_hsnl_checker (.*);
